@@ hw/rtl/aup_pkg.sv @@
// Shared widths, status codes and word types of the ASCII unsigned parser.
package aup_pkg;

  // Default sizes of the position counter and the accumulator.
  localparam int unsigned PosBitsDef   = 16;
  localparam int unsigned ValueBitsDef = 32;

  // Fixed port widths.
  localparam int unsigned CharW   = 8;
  localparam int unsigned RadixW  = 8;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned OffsetW = 16;
  localparam int unsigned StatusW = 2;

  // Largest explicit radix and the width of the active radix register.
  localparam int unsigned RadixMax = 36;
  localparam int unsigned BaseW    = 6;

  localparam logic [StatusW-1:0] StatusOk       = 2'd0;
  localparam logic [StatusW-1:0] StatusBadRadix = 2'd1;
  localparam logic [StatusW-1:0] StatusOverflow = 2'd2;

  typedef struct packed {
    logic [CharW-1:0]  ch;
    logic              first;
    logic [RadixW-1:0] radix;
  } aup_char_t;

  typedef struct packed {
    logic [ValueW-1:0]  value;
    logic [OffsetW-1:0] end_offset;
    logic               end_valid;
    logic [StatusW-1:0] status;
  } aup_res_t;

endpackage

@@ hw/rtl/aup_if.sv @@
// Handshake interfaces for the character stream and the result stream.
interface aup_char_if import aup_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CharW-1:0]  ch;
  logic              first;
  logic [RadixW-1:0] radix;

  modport source (output valid, output ch, output first, output radix, input ready);
  modport sink   (input valid, input ch, input first, input radix, output ready);
endinterface

interface aup_res_if import aup_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ValueW-1:0]  value;
  logic [OffsetW-1:0] end_offset;
  logic               end_valid;
  logic [StatusW-1:0] status;

  modport source (output valid, output value, output end_offset, output end_valid,
                  output status, input ready);
  modport sink   (input valid, input value, input end_offset, input end_valid,
                  input status, output ready);
endinterface

@@ hw/rtl/aup_in_stage.sv @@
// Input register that holds one character word for the parse stage.
module aup_in_stage import aup_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  aup_char_t in_item_i,
  output logic      in_ready_o,
  output logic      item_valid_o,
  output aup_char_t item_o,
  input  logic      item_take_i
);

  logic      valid_q;
  aup_char_t item_q;

  // A new word may enter when the register is empty or the held one leaves in the same cycle.
  assign in_ready_o = !valid_q || item_take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

@@ hw/rtl/aup_parse.sv @@
// Parse state and the per-character next-state and result logic.
module aup_parse import aup_pkg::*; #(
  parameter int unsigned POS_BITS   = PosBitsDef,
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      item_valid_i,
  input  aup_char_t item_i,
  input  logic      take_i,
  output logic      res_valid_o,
  output aup_res_t  res_o
);

  localparam int unsigned ProdW = VALUE_BITS + BaseW;

  localparam logic [2:0] PhIdle   = 3'd0;
  localparam logic [2:0] PhSpace  = 3'd1;
  localparam logic [2:0] PhSigned = 3'd2;
  localparam logic [2:0] PhZero   = 3'd3;
  localparam logic [2:0] PhDigits = 3'd4;

  localparam logic [CharW-1:0] CharNul   = 8'h00;
  localparam logic [CharW-1:0] CharTab   = 8'h09;
  localparam logic [CharW-1:0] CharLf    = 8'h0A;
  localparam logic [CharW-1:0] CharCr    = 8'h0D;
  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic [CharW-1:0] CharPlus  = 8'h2B;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [CharW-1:0] CharUpA   = 8'h41;
  localparam logic [CharW-1:0] CharUpX   = 8'h58;
  localparam logic [CharW-1:0] CharUpZ   = 8'h5A;
  localparam logic [CharW-1:0] CharLowA  = 8'h61;
  localparam logic [CharW-1:0] CharLowX  = 8'h78;
  localparam logic [CharW-1:0] CharLowZ  = 8'h7A;

  localparam logic [BaseW-1:0] BaseOct = 6'd8;
  localparam logic [BaseW-1:0] BaseDec = 6'd10;
  localparam logic [BaseW-1:0] BaseHex = 6'd16;
  localparam logic [BaseW-1:0] NoDigit = 6'd63;

  // Digit value of a character, or a value above every radix if it is no digit.
  function automatic logic [BaseW-1:0] char_digit(input logic [CharW-1:0] c);
    logic [CharW-1:0] t;
    if (c >= CharZero && c <= CharNine) begin
      t = c - CharZero;
    end else if (c >= CharLowA && c <= CharLowZ) begin
      t = c - CharLowA + 8'd10;
    end else if (c >= CharUpA && c <= CharUpZ) begin
      t = c - CharUpA + 8'd10;
    end else begin
      t = CharW'(NoDigit);
    end
    return t[BaseW-1:0];
  endfunction

  logic [2:0]            phase_q, phase_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [BaseW-1:0]      radix_q, radix_d;
  logic                  neg_q, neg_d;
  logic                  ovf_q, ovf_d;
  logic                  seen_q, seen_d;
  logic [POS_BITS-1:0]   pos_q, pos_d;

  logic [2:0]       cur_phase;
  logic             start_num;
  logic             do_digit;
  logic             emit;
  logic [CharW-1:0] c;
  logic [BaseW-1:0] dig;
  logic [ProdW-1:0] prod;
  aup_res_t         res;

  assign c   = item_i.ch;
  assign dig = char_digit(item_i.ch);

  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    radix_d   = radix_q;
    neg_d     = neg_q;
    ovf_d     = ovf_q;
    seen_d    = seen_q;
    pos_d     = pos_q;
    cur_phase = phase_q;
    start_num = 1'b0;
    do_digit  = 1'b0;
    emit      = 1'b0;
    prod      = '0;
    res       = '0;

    if (item_i.first) begin
      acc_d  = '0;
      radix_d = '0;
      neg_d  = 1'b0;
      ovf_d  = 1'b0;
      seen_d = 1'b0;
      pos_d  = '0;
      if (item_i.radix == 8'd1 || item_i.radix > RadixW'(RadixMax)) begin
        emit       = 1'b1;
        res.status = StatusBadRadix;
        phase_d    = PhIdle;
        cur_phase  = PhIdle;
      end else begin
        radix_d   = item_i.radix[BaseW-1:0];
        phase_d   = PhSpace;
        cur_phase = PhSpace;
      end
    end

    unique case (cur_phase)
      PhIdle: begin
      end
      PhSpace: begin
        if (c == CharSpace || c == CharTab || c == CharCr || c == CharLf) begin
          pos_d = pos_d + POS_BITS'(1);
        end else if (c == CharMinus || c == CharPlus) begin
          neg_d   = (c == CharMinus);
          phase_d = PhSigned;
          pos_d   = pos_d + POS_BITS'(1);
        end else begin
          start_num = 1'b1;
        end
      end
      PhSigned: begin
        start_num = 1'b1;
      end
      PhZero: begin
        if (c == CharLowX || c == CharUpX) begin
          radix_d = BaseHex;
          seen_d  = 1'b0;
          phase_d = PhDigits;
          pos_d   = pos_d + POS_BITS'(1);
        end else begin
          if (radix_d == '0) begin
            radix_d = BaseOct;
          end
          acc_d    = '0;
          seen_d   = 1'b1;
          phase_d  = PhDigits;
          do_digit = 1'b1;
        end
      end
      PhDigits: begin
        do_digit = 1'b1;
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase

    // A leading zero may open a hex or octal prefix; anything else is a digit.
    if (start_num) begin
      if (c == CharZero && (radix_d == '0 || radix_d == BaseHex)) begin
        phase_d = PhZero;
        pos_d   = pos_d + POS_BITS'(1);
      end else begin
        if (radix_d == '0) begin
          radix_d = BaseDec;
        end
        do_digit = 1'b1;
      end
    end

    if (do_digit) begin
      if (c == CharNul) begin
        emit           = 1'b1;
        phase_d        = PhIdle;
        res.end_offset = OffsetW'(pos_d);
        res.end_valid  = 1'b1;
        if (ovf_d) begin
          res.value  = ValueW'({VALUE_BITS{1'b1}});
          res.status = StatusOverflow;
        end else if (neg_d) begin
          res.value  = ValueW'({VALUE_BITS{1'b0}} - acc_d);
          res.status = StatusOk;
        end else begin
          res.value  = ValueW'(acc_d);
          res.status = StatusOk;
        end
      end else if (radix_d < 6'd2 || dig >= radix_d) begin
        // An invalid digit ends the string without sign or saturation.
        emit           = 1'b1;
        phase_d        = PhIdle;
        res.value      = ValueW'(acc_d);
        res.end_offset = seen_d ? OffsetW'(pos_d) : '0;
        res.end_valid  = 1'b1;
        res.status     = StatusOk;
      end else begin
        prod = ProdW'(acc_d) * ProdW'(radix_d);
        if (prod[ProdW-1:VALUE_BITS] != '0) begin
          ovf_d = 1'b1;
        end
        acc_d   = prod[VALUE_BITS-1:0] + VALUE_BITS'(dig);
        seen_d  = 1'b1;
        phase_d = PhDigits;
        pos_d   = pos_d + POS_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      acc_q   <= '0;
      radix_q <= '0;
      neg_q   <= 1'b0;
      ovf_q   <= 1'b0;
      seen_q  <= 1'b0;
      pos_q   <= '0;
    end else if (item_valid_i && take_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      radix_q <= radix_d;
      neg_q   <= neg_d;
      ovf_q   <= ovf_d;
      seen_q  <= seen_d;
      pos_q   <= pos_d;
    end
  end

  assign res_valid_o = item_valid_i && emit;
  assign res_o       = res;

endmodule

@@ hw/rtl/aup_out_stage.sv @@
// Result register that holds one result word until the sink takes it.
module aup_out_stage import aup_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  aup_res_t res_i,
  output logic     load_ready_o,
  output logic     out_valid_o,
  output aup_res_t out_o,
  input  logic     out_ready_i
);

  logic     valid_q;
  aup_res_t res_q;

  assign load_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ready_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule

@@ hw/rtl/ascii_to_unsigned_parser.sv @@
// Top level of the ASCII unsigned parser: input register, parse stage, result register.
//
// The parser takes one character word per cycle and keeps that rate with no gaps
// as long as the result sink does not stall. A character is registered in the
// input register when it is accepted and processed when the parse stage takes
// it. The result word is loaded into the result register when the character
// that ends the string is taken (its NUL, the first invalid digit, or a first
// character with a bad radix), and is offered on res_o from then on. The per-cycle
// rate rests on the digit step, a multiply of the accumulator by the radix plus the
// digit and an overflow test on the full product, done combinationally on the parse
// state. A stalled result holds the parse stage whether or not the waiting character
// ends a string, and in_i.ready is low while the input register holds an untaken word.
module ascii_to_unsigned_parser import aup_pkg::*; #(
  parameter int unsigned POS_BITS   = PosBitsDef,
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  aup_char_if.sink        in_i,
  aup_res_if.source       res_o
);

  aup_char_t in_item;
  aup_char_t item;
  logic      item_valid;
  logic      take;
  logic      load_ready;
  logic      res_valid;
  aup_res_t  res;
  aup_res_t  out_res;

  assign in_item.ch    = in_i.ch;
  assign in_item.first = in_i.first;
  assign in_item.radix = in_i.radix;

  assign take = item_valid && load_ready;

  aup_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_item_i    (in_item),
    .in_ready_o   (in_i.ready),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (take)
  );

  aup_parse #(
    .POS_BITS   (POS_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_i       (take),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  aup_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (take && res_valid),
    .res_i        (res),
    .load_ready_o (load_ready),
    .out_valid_o  (res_o.valid),
    .out_o        (out_res),
    .out_ready_i  (res_o.ready)
  );

  assign res_o.value      = out_res.value;
  assign res_o.end_offset = out_res.end_offset;
  assign res_o.end_valid  = out_res.end_valid;
  assign res_o.status     = out_res.status;

endmodule

@@ hw/rtl/aup_checker.sv @@
// Port-level checks of the result stream of the ASCII unsigned parser, bound to the top.
module aup_checker import aup_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [ValueW-1:0]  value_i,
  input logic [OffsetW-1:0] end_offset_i,
  input logic               end_valid_i,
  input logic [StatusW-1:0] status_i
);

  // A stalled result word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(value_i) && $stable(end_offset_i)
                                    && $stable(end_valid_i) && $stable(status_i))
    else $error("result payload changed while stalled");

  // A bad radix reports nothing but its status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == StatusBadRadix |->
      value_i == '0 && end_offset_i == '0 && !end_valid_i)
    else $error("bad radix result carries data");

  // Only a bad radix leaves the end offset meaningless.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !end_valid_i |-> status_i == StatusBadRadix)
    else $error("end offset invalid without bad radix");

  // A saturated result has its low 16 value bits all ones and has an end offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == StatusOverflow |-> end_valid_i && value_i[15:0] == 16'hFFFF)
    else $error("overflow result not saturated");

endmodule

bind ascii_to_unsigned_parser aup_checker u_aup_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .value_i      (res_o.value),
  .end_offset_i (res_o.end_offset),
  .end_valid_i  (res_o.end_valid),
  .status_i     (res_o.status)
);

@@ tb/ascii_to_unsigned_parser_tb.sv @@
// Self-checking testbench of the ASCII unsigned parser with a cycle-free parse predictor.
module ascii_to_unsigned_parser_tb;
  import aup_pkg::*;

  localparam int unsigned RandomItems = 1000;
  localparam int unsigned LongRun     = 40;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DirCount    = 27;
  localparam longint unsigned LimitTime = 64'd20_000_000;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] NoDigit = 8'hff;

  typedef enum logic [2:0] {
    ScanIdle, ScanSpace, ScanSigned, ScanZero, ScanDigits
  } scan_phase_e;

  typedef struct packed {
    logic [CharW-1:0]   ch;
    logic               first;
    logic [RadixW-1:0]  radix;
    logic               typed;
    logic [ValueW-1:0]  value;
    logic [OffsetW-1:0] end_offset;
    logic               end_valid;
    logic [StatusW-1:0] status;
  } char_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  aup_char_if char_if ();
  aup_res_if  res_if ();

  ascii_to_unsigned_parser DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (char_if),
    .res_o  (res_if)
  );

  always #5 clk_i = ~clk_i;

  // Predicted parse state.
  scan_phase_e        scan_phase = ScanIdle;
  logic [ValueW-1:0]  num_acc = '0;
  logic [BaseW-1:0]   num_base = '0;
  logic               num_neg = 1'b0;
  logic               num_ovf = 1'b0;
  logic               num_seen = 1'b0;
  logic [OffsetW-1:0] num_pos = '0;

  aup_res_t pending_numbers[$];
  int unsigned mismatches = 0;
  int unsigned counted = 0;
  bit src_idle = 1'b0;
  bit sink_idle = 1'b0;
  bit hold_req = 1'b0;
  bit start_pending = 1'b0;
  logic [RadixW-1:0] cur_radix = '0;

  // Directed strings; rows with typed set carry a result read straight off the spec.
  char_row_t dir_rows [DirCount] = '{
    '{"5",     1'b1, 8'd1,   1'b1, 32'd0, 16'd0, 1'b0, StatusBadRadix},
    '{ChNul,   1'b1, 8'd255, 1'b1, 32'd0, 16'd0, 1'b0, StatusBadRadix},
    '{"7",     1'b0, 8'd0,   1'b0, 32'd0, 16'd0, 1'b0, StatusOk},
    '{ChNul,   1'b1, 8'd10,  1'b1, 32'd0, 16'd0, 1'b1, StatusOk},
    '{8'hff,   1'b1, 8'd36,  1'b1, 32'd0, 16'd0, 1'b1, StatusOk},
    '{ChTab,   1'b1, 8'd0,   1'b0, 32'd0, 16'd0, 1'b0, StatusOk},
    '{ChLf,    1'b0, 8'hff,  1'b0, 32'd0, 16'd0, 1'b0, StatusOk},
    '{ChMinus, 1'b0, 8'd0,   1'b0, 32'd0, 16'd0, 1'b0, StatusOk},
    '{ChZero,  1'b0, 8'd0,   1'b0, 32'd0, 16'd0, 1'b0, StatusOk},
    '{"x",     1'b0, 8'd0,   1'b0, 32'd0, 16'd0, 1'b0, StatusOk},
    '{"F",     1'b0, 8'd0,   1'b0, 32'd0, 16'd0, 1'b0, StatusOk},
    '{ChNul,   1'b0, 8'd0,   1'b0, 32'd0, 16'd0, 1'b0, StatusOk},
    '{"1",     1'b1, 8'd2,   1'b0, 32'd0, 16'd0, 1'b0, StatusOk},
    '{ChZero,  1'b0, 8'd0,   1'b0, 32'd0, 16'd0, 1'b0, StatusOk},
    '{ChZero,  1'b1, 8'd16,  1'b0, 32'd0, 16'd0, 1'b0, StatusOk},
    '{"X",     1'b0, 8'd0,   1'b0, 32'd0, 16'd0, 1'b0, StatusOk},
    '{"g",     1'b0, 8'd0,   1'b0, 32'd0, 16'd0, 1'b0, StatusOk},
    '{ChZero,  1'b1, 8'd0,   1'b0, 32'd0, 16'd0, 1'b0, StatusOk},
    '{"8",     1'b0, 8'd0,   1'b0, 32'd0, 16'd0, 1'b0, StatusOk},
    '{"z",     1'b1, 8'd36,  1'b0, 32'd0, 16'd0, 1'b0, StatusOk},
    '{"z",     1'b0, 8'd0,   1'b0, 32'd0, 16'd0, 1'b0, StatusOk},
    '{"z",     1'b0, 8'd0,   1'b0, 32'd0, 16'd0, 1'b0, StatusOk},
    '{"z",     1'b0, 8'd0,   1'b0, 32'd0, 16'd0, 1'b0, StatusOk},
    '{"z",     1'b0, 8'd0,   1'b0, 32'd0, 16'd0, 1'b0, StatusOk},
    '{"z",     1'b0, 8'd0,   1'b0, 32'd0, 16'd0, 1'b0, StatusOk},
    '{"z",     1'b0, 8'd0,   1'b0, 32'd0, 16'd0, 1'b0, StatusOk},
    '{ChNul,   1'b0, 8'd0,   1'b1, 32'hffffffff, 16'd7, 1'b1, StatusOverflow}
  };

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "z") return c - "a" + 8'd10;
    if (c >= "A" && c <= "Z") return c - "A" + 8'd10;
    return NoDigit;
  endfunction

  function automatic bit close_number(input logic [ValueW-1:0] v, input logic [OffsetW-1:0] off,
                                      input logic ev, input logic [StatusW-1:0] st,
                                      output aup_res_t res);
    res.value      = v;
    res.end_offset = off;
    res.end_valid  = ev;
    res.status     = st;
    scan_phase     = ScanIdle;
    return 1'b1;
  endfunction

  function automatic bit accumulate(input logic [7:0] c, output aup_res_t res);
    logic [7:0]  d;
    logic [63:0] product;
    if (c == ChNul) begin
      if (num_ovf) return close_number('1, num_pos, 1'b1, StatusOverflow, res);
      if (num_neg) return close_number(-num_acc, num_pos, 1'b1, StatusOk, res);
      return close_number(num_acc, num_pos, 1'b1, StatusOk, res);
    end
    d = digit_value(c);
    if (num_base < 2 || d >= num_base)
      return close_number(num_acc, num_seen ? num_pos : '0, 1'b1, StatusOk, res);
    product = {32'd0, num_acc} * num_base;
    // The overflow test looks at the full product; the added digit just wraps.
    if (product > 64'hffffffff) num_ovf = 1'b1;
    num_acc    = product[31:0] + d;
    num_seen   = 1'b1;
    scan_phase = ScanDigits;
    num_pos++;
    return 1'b0;
  endfunction

  function automatic bit begin_number(input logic [7:0] c, output aup_res_t res);
    if (c == ChZero && (num_base == 0 || num_base == 16)) begin
      scan_phase = ScanZero;
      num_pos++;
      return 1'b0;
    end
    if (num_base == 0) num_base = 6'd10;
    return accumulate(c, res);
  endfunction

  function automatic bit parse_step(input logic [7:0] c, input logic f, input logic [7:0] r,
                                    output aup_res_t res);
    res = '0;
    if (f) begin
      scan_phase = ScanIdle;
      num_acc    = '0;
      num_base   = '0;
      num_neg    = 1'b0;
      num_ovf    = 1'b0;
      num_seen   = 1'b0;
      num_pos    = '0;
      if (r == 1 || r > RadixMax) return close_number('0, '0, 1'b0, StatusBadRadix, res);
      num_base   = r[BaseW-1:0];
      scan_phase = ScanSpace;
    end else if (scan_phase == ScanIdle) begin
      return 1'b0;
    end
    case (scan_phase)
      ScanSpace: begin
        if (c == ChSpace || c == ChTab || c == ChCr || c == ChLf) begin
          num_pos++;
          return 1'b0;
        end
        if (c == ChMinus || c == ChPlus) begin
          num_neg    = (c == ChMinus);
          scan_phase = ScanSigned;
          num_pos++;
          return 1'b0;
        end
        return begin_number(c, res);
      end
      ScanSigned: return begin_number(c, res);
      ScanZero: begin
        if (c == "x" || c == "X") begin
          num_base   = 6'd16;
          num_seen   = 1'b0;
          scan_phase = ScanDigits;
          num_pos++;
          return 1'b0;
        end
        if (num_base == 0) num_base = 6'd8;
        num_acc    = '0;
        num_seen   = 1'b1;
        scan_phase = ScanDigits;
        return accumulate(c, res);
      end
      ScanDigits: return accumulate(c, res);
      default: begin
        scan_phase = ScanIdle;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic send_char(input logic [7:0] c, input logic f, input logic [7:0] r,
                           input bit typed, input aup_res_t want);
    int unsigned gap;
    aup_res_t    predicted;
    bit          produced;
    gap = src_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      char_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    char_if.valid <= 1'b1;
    char_if.ch    <= c;
    char_if.first <= f;
    char_if.radix <= r;
    do @(posedge clk_i); while (!char_if.ready);
    if (f || scan_phase != ScanIdle) counted++;
    produced = parse_step(c, f, r, predicted);
    if (typed) pending_numbers.push_back(want);
    else if (produced) pending_numbers.push_back(predicted);
    @(negedge clk_i);
  endtask

  // Sends one character of the current random string; the first one carries the radix.
  task automatic put_char(input logic [7:0] c);
    logic [7:0] r;
    r = start_pending ? cur_radix : 8'($urandom);
    send_char(c, start_pending, r, 1'b0, '0);
    start_pending = 1'b0;
  endtask

  function automatic logic [7:0] digit_char(input int unsigned d);
    if (d < 10) return ChZero + 8'(d);
    return ($urandom_range(0, 1) ? "a" : "A") + 8'(d - 10);
  endfunction

  task automatic random_string();
    int unsigned kind;
    int unsigned digit_base;
    int unsigned n;
    int unsigned d;
    kind = $urandom_range(0, 99);
    if (kind < 8) cur_radix = $urandom_range(0, 1) ? 8'd1 : 8'($urandom_range(37, 255));
    else if (kind < 35) cur_radix = 8'd0;
    else if (kind < 55) cur_radix = 8'd16;
    else if (kind < 65) cur_radix = 8'd10;
    else cur_radix = 8'($urandom_range(2, 36));
    start_pending = 1'b1;
    if (kind < 8) begin
      put_char(8'($urandom));
      return;
    end
    n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: put_char(ChSpace);
        1: put_char(ChTab);
        2: put_char(ChCr);
        default: put_char(ChLf);
      endcase
    end
    case ($urandom_range(0, 3))
      0: put_char(ChPlus);
      1: put_char(ChMinus);
      default: ;
    endcase
    digit_base = cur_radix == 0 ? 10 : cur_radix;
    if ((cur_radix == 0 || cur_radix == 16) && $urandom_range(0, 2) == 0) begin
      put_char(ChZero);
      if ($urandom_range(0, 3) != 0) begin
        put_char($urandom_range(0, 1) ? "x" : "X");
        digit_base = 16;
      end else if (cur_radix == 0) begin
        digit_base = 8;
      end
    end
    n = $urandom_range(0, 4) == 0 ? $urandom_range(8, 14) : $urandom_range(0, 7);
    repeat (n) begin
      d = $urandom_range(0, 29) == 0 ? $urandom_range(0, 35) : $urandom_range(0, digit_base - 1);
      put_char(digit_char(d));
    end
    // Mostly NUL ends; otherwise a stray byte, a random byte then NUL, or the string is abandoned by the next start.
    kind = $urandom_range(0, 9);
    if (kind < 6) put_char(ChNul);
    else if (kind < 8) put_char(8'($urandom_range(1, 255)));
    else if (kind == 9) begin
      put_char(8'($urandom));
      put_char(ChNul);
    end
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 2)) put_char(8'($urandom));
    end
  endtask

  task automatic check_word();
    aup_res_t got;
    aup_res_t want;
    got.value      = res_if.value;
    got.end_offset = res_if.end_offset;
    got.end_valid  = res_if.end_valid;
    got.status     = res_if.status;
    if (pending_numbers.size() == 0) begin
      $error("unexpected result word: value %h offset %0d", got.value, got.end_offset);
      mismatches++;
      return;
    end
    want = pending_numbers.pop_front();
    if (got.value !== want.value) begin
      $error("value mismatch: expected %h, got %h", want.value, got.value);
      mismatches++;
    end
    if (got.end_offset !== want.end_offset) begin
      $error("end_offset mismatch: expected %0d, got %0d", want.end_offset, got.end_offset);
      mismatches++;
    end
    if (got.end_valid !== want.end_valid) begin
      $error("end_valid mismatch: expected %b, got %b", want.end_valid, got.end_valid);
      mismatches++;
    end
    if (got.status !== want.status) begin
      $error("status mismatch: expected %0d, got %0d", want.status, got.status);
      mismatches++;
    end
  endtask

  // Result side: random stalls, plus one long hold-off that backs up the input.
  initial begin
    int unsigned stall;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        stall    = HoldCycles;
        hold_req = 1'b0;
      end else begin
        stall = sink_idle ? $urandom_range(0, 13) : 0;
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      check_word();
      @(negedge clk_i);
    end
  end

  initial begin
    #(LimitTime);
    $display("FAIL");
    $finish;
  end

  initial begin
    aup_res_t want;
    char_if.valid = 1'b0;
    char_if.ch    = '0;
    char_if.first = 1'b0;
    char_if.radix = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    src_idle  = 1'b1;
    sink_idle = 1'b1;
    foreach (dir_rows[i]) begin
      want.value      = dir_rows[i].value;
      want.end_offset = dir_rows[i].end_offset;
      want.end_valid  = dir_rows[i].end_valid;
      want.status     = dir_rows[i].status;
      send_char(dir_rows[i].ch, dir_rows[i].first, dir_rows[i].radix, dir_rows[i].typed, want);
    end

    // A long run of leading blanks sent back to back.
    src_idle = 1'b0;
    send_char(ChSpace, 1'b1, 8'd10, 1'b0, '0);
    repeat (LongRun) send_char(ChSpace, 1'b0, 8'($urandom), 1'b0, '0);
    send_char("4", 1'b0, 8'd0, 1'b0, '0);
    send_char("2", 1'b0, 8'd0, 1'b0, '0);
    send_char(ChNul, 1'b0, 8'd0, 1'b0, '0);

    counted  = 0;
    hold_req = 1'b1;
    while (counted < RandomItems) begin
      if ($urandom_range(0, 19) == 0) begin
        src_idle  = $urandom_range(0, 1);
        sink_idle = $urandom_range(0, 1);
      end
      random_string();
    end
    char_if.valid <= 1'b0;

    while (pending_numbers.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/aup_pkg.sv
hw/rtl/aup_if.sv
hw/rtl/aup_in_stage.sv
hw/rtl/aup_parse.sv
hw/rtl/aup_out_stage.sv
hw/rtl/ascii_to_unsigned_parser.sv
hw/rtl/aup_checker.sv
tb/ascii_to_unsigned_parser_tb.sv
